### hw/rtl/rme_pkg.sv
package rme_pkg;

    // Register file geometry.
    localparam int NUM_REGISTERS = 6;
    localparam int REG_IDX_W     = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;

    // Field widths.
    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int OPERAND_W  = 31;
    localparam int DEST_W     = 3;
    localparam int BOUND_W    = 3;
    localparam int LENGTH_W   = 9;
    localparam int CFG_DATA_W = 9;

    localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(31);

    typedef enum logic [3:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } opcode_t;

    typedef enum logic [0:0] {
        CFG_BOUND_REGISTER = 1'b0,
        CFG_PROGRAM_LENGTH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [OPERAND_W-1:0]  operand_a;
        logic [OPERAND_W-1:0]  operand_b;
        logic [DEST_W-1:0]     operand_c;
    } instr_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] next_pointer;
        logic signed [WORD_W-1:0] written_value;
        logic                     halted;
        logic                     bad_index;
    } result_t;

    // True when the opcode reads operand A as a register index.
    function automatic logic reads_reg_a(opcode_t op);
        logic r;
        case (op)
            OP_SETI, OP_GTIR, OP_EQIR: r = 1'b0;
            default:                   r = 1'b1;
        endcase
        return r;
    endfunction

    // True when the opcode reads operand B as a register index.
    function automatic logic reads_reg_b(opcode_t op);
        logic r;
        case (op)
            OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
            OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: r = 1'b1;
            default:                            r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_mul(opcode_t op);
        return (op == OP_MULR) || (op == OP_MULI);
    endfunction

    // A register index is legal when it falls inside the register file.
    function automatic logic idx_ok(logic [OPERAND_W-1:0] idx);
        return {1'b0, idx} < 32'(NUM_REGISTERS);
    endfunction

endpackage

### hw/rtl/rme_instr_if.sv
interface rme_instr_if
    import rme_pkg::*;
;
    logic   valid;
    logic   ready;
    instr_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/rme_result_if.sv
interface rme_result_if
    import rme_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/rme_cfg_if.sv
interface rme_cfg_if
    import rme_pkg::*;
;
    logic                  valid;
    logic                  ready;
    cfg_reg_t              index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

### hw/rtl/register_machine_execute.sv
// Each instruction is registered into the execute stage and its result into the
// output register; a multiply first registers its 32-bit partial products.
// Throughput: one instruction per cycle while the result channel does not stall;
// a multiply holds the execute stage until its 64-bit product is complete.
// Reset clears the pointer and both channel stages and makes every register read
// as zero; the bound register resets to 0 and the program length to 31.
module register_machine_execute
    import rme_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rme_instr_if.sink    instr,
    rme_cfg_if.sink      cfg,
    rme_result_if.source result
);

    // Configuration and architectural state.
    logic [BOUND_W-1:0]  bound_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic [WORD_W-1:0]   ip_reg;
    logic                bound_live_reg;

    // Register file: one write port, read at two addresses on capture.
    logic [WORD_W-1:0]        rf_mem [NUM_REGISTERS];
    logic [NUM_REGISTERS-1:0] rf_valid_reg;

    // Execute stage input register.
    logic                instr_valid_reg;
    instr_t              instr_reg;
    logic [WORD_W-1:0]   rd_a_reg;
    logic [WORD_W-1:0]   rd_b_reg;
    logic                rd_a_valid_reg;
    logic                rd_b_valid_reg;
    logic                rd_a_byp_reg;
    logic                rd_b_byp_reg;
    logic [WORD_W-1:0]   byp_data_reg;

    // Multiply partial products.
    logic                mul_phase_reg;
    logic [WORD_W-1:0]   pp_lo_reg;
    logic [HALF_W-1:0]   pp_cross_reg;
    logic [WORD_W-1:0]   pp_lo_next;
    logic [HALF_W-1:0]   pp_cross_next;
    logic [HALF_W-1:0]   cross_xy;
    logic [HALF_W-1:0]   cross_yx;

    // Output register.
    logic                out_valid_reg;
    result_t             out_data_reg;

    // Handshake and write port control.
    logic                out_free;
    logic                capture;
    logic                cfg_fire;
    logic                mul_first;
    logic                exec_done;
    logic                wr_en;
    logic [REG_IDX_W-1:0] wr_idx;
    logic [WORD_W-1:0]   wr_data;
    logic                flush_we;
    logic [REG_IDX_W-1:0] rd_a_idx;
    logic [REG_IDX_W-1:0] rd_b_idx;

    // Execute datapath.
    opcode_t             op;
    logic                a_ok;
    logic                b_ok;
    logic                c_ok;
    logic                bound_ok;
    logic                a_is_bound;
    logic                b_is_bound;
    logic                c_is_bound;
    logic [WORD_W-1:0]   stored_a;
    logic [WORD_W-1:0]   stored_b;
    logic [WORD_W-1:0]   reg_a_val;
    logic [WORD_W-1:0]   reg_b_val;
    logic [WORD_W-1:0]   x_val;
    logic [WORD_W-1:0]   y_val;
    logic [WORD_W-1:0]   value;
    logic [WORD_W-1:0]   nxt;
    logic                bad;
    result_t             res;

    // Channel handshakes.
    assign out_free    = !out_valid_reg || result.ready;
    assign instr.ready = !instr_valid_reg || exec_done;
    assign capture     = instr.valid && instr.ready;
    assign cfg.ready   = !instr_valid_reg;
    assign cfg_fire    = cfg.valid && cfg.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Execute stage sequencing: a multiply first registers its partial products.
    always_comb
    begin
        op        = instr_reg.opcode;
        mul_first = instr_valid_reg && is_mul(op) && !mul_phase_reg;
        exec_done = instr_valid_reg && (!is_mul(op) || mul_phase_reg) && out_free;
    end

    // Operand fetch, with the bound register showing the current pointer.
    always_comb
    begin
        a_ok       = idx_ok(instr_reg.operand_a);
        b_ok       = idx_ok(instr_reg.operand_b);
        c_ok       = idx_ok(OPERAND_W'(instr_reg.operand_c));
        bound_ok   = idx_ok(OPERAND_W'(bound_reg));
        a_is_bound = bound_ok && (instr_reg.operand_a[REG_IDX_W-1:0] == bound_reg[REG_IDX_W-1:0]);
        b_is_bound = bound_ok && (instr_reg.operand_b[REG_IDX_W-1:0] == bound_reg[REG_IDX_W-1:0]);
        c_is_bound = bound_ok && c_ok && (instr_reg.operand_c == bound_reg);

        stored_a = rd_a_byp_reg ? byp_data_reg : (rd_a_valid_reg ? rd_a_reg : '0);
        stored_b = rd_b_byp_reg ? byp_data_reg : (rd_b_valid_reg ? rd_b_reg : '0);

        if (!a_ok)
            reg_a_val = '0;
        else if (a_is_bound)
            reg_a_val = ip_reg;
        else
            reg_a_val = stored_a;

        if (!b_ok)
            reg_b_val = '0;
        else if (b_is_bound)
            reg_b_val = ip_reg;
        else
            reg_b_val = stored_b;

        x_val = reads_reg_a(op) ? reg_a_val : WORD_W'(instr_reg.operand_a);
        y_val = reads_reg_b(op) ? reg_b_val : WORD_W'(instr_reg.operand_b);

        bad = (reads_reg_a(op) && !a_ok) || (reads_reg_b(op) && !b_ok) || !c_ok;
    end

    // Partial products of the wrapped 64-bit multiply.
    always_comb
    begin
        pp_lo_next    = x_val[HALF_W-1:0] * y_val[HALF_W-1:0];
        cross_xy      = x_val[HALF_W-1:0] * y_val[WORD_W-1:HALF_W];
        cross_yx      = x_val[WORD_W-1:HALF_W] * y_val[HALF_W-1:0];
        pp_cross_next = cross_xy + cross_yx;
    end

    // Opcode result, next pointer and halt flag.
    always_comb
    begin
        case (op)
            OP_ADDR, OP_ADDI: value = x_val + y_val;
            OP_MULR, OP_MULI: value = pp_lo_reg + {pp_cross_reg, {HALF_W{1'b0}}};
            OP_BANR, OP_BANI: value = x_val & y_val;
            OP_BORR, OP_BORI: value = x_val | y_val;
            OP_SETR, OP_SETI: value = x_val;
            OP_GTIR, OP_GTRI, OP_GTRR:
                value = WORD_W'($signed(x_val) > $signed(y_val));
            OP_EQIR, OP_EQRI, OP_EQRR:
                value = WORD_W'(x_val == y_val);
            default: value = '0;
        endcase

        // The bound register holds the old pointer unless this write lands on it.
        nxt = c_is_bound ? (value + WORD_W'(1)) : (ip_reg + WORD_W'(1));

        res.next_pointer  = nxt;
        res.written_value = value;
        res.halted        = nxt[WORD_W-1] || (nxt >= WORD_W'(length_reg));
        res.bad_index     = bad;
    end

    // Register file write port: the destination write of a completed
    // instruction, or the bound register's value when configuration rebinds it.
    always_comb
    begin
        flush_we = cfg_fire && (cfg.index == CFG_BOUND_REGISTER) && bound_live_reg;
        if (exec_done && c_ok)
        begin
            wr_en   = 1'b1;
            wr_idx  = instr_reg.operand_c[REG_IDX_W-1:0];
            wr_data = value;
        end
        else
        begin
            wr_en   = flush_we;
            wr_idx  = bound_reg[REG_IDX_W-1:0];
            wr_data = ip_reg - WORD_W'(1);
        end
        rd_a_idx = instr.data.operand_a[REG_IDX_W-1:0];
        rd_b_idx = instr.data.operand_b[REG_IDX_W-1:0];
    end

    // Register file storage and capture-time reads with write bypass.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rf_mem[wr_idx] <= wr_data;
        if (capture)
        begin
            instr_reg      <= instr.data;
            rd_a_reg       <= rf_mem[rd_a_idx];
            rd_b_reg       <= rf_mem[rd_b_idx];
            rd_a_valid_reg <= rf_valid_reg[rd_a_idx];
            rd_b_valid_reg <= rf_valid_reg[rd_b_idx];
            rd_a_byp_reg   <= wr_en && (wr_idx == rd_a_idx);
            rd_b_byp_reg   <= wr_en && (wr_idx == rd_b_idx);
            byp_data_reg   <= wr_data;
        end
        if (mul_first)
        begin
            pp_lo_reg    <= pp_lo_next;
            pp_cross_reg <= pp_cross_next;
        end
        if (exec_done)
            out_data_reg <= res;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg       <= '0;
            length_reg      <= LENGTH_RESET;
            ip_reg          <= '0;
            bound_live_reg  <= 1'b0;
            rf_valid_reg    <= '0;
            instr_valid_reg <= 1'b0;
            mul_phase_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
                rf_valid_reg[wr_idx] <= 1'b1;

            if (capture)
                instr_valid_reg <= 1'b1;
            else if (exec_done)
                instr_valid_reg <= 1'b0;

            if (mul_first)
                mul_phase_reg <= 1'b1;
            else if (exec_done)
                mul_phase_reg <= 1'b0;

            if (exec_done)
            begin
                ip_reg <= nxt;
                if (bound_ok)
                    bound_live_reg <= 1'b1;
            end

            if (exec_done)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            // Configuration writes.
            if (cfg_fire)
            begin
                case (cfg.index)
                    CFG_BOUND_REGISTER:
                    begin
                        bound_reg      <= cfg.wdata[BOUND_W-1:0];
                        bound_live_reg <= 1'b0;
                    end
                    CFG_PROGRAM_LENGTH: length_reg <= cfg.wdata[LENGTH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### hw/rtl/rme_checker.sv
module rme_checker
    import rme_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    instr_ready,
    input logic    cfg_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_data
);

    // No result is offered while reset is held.
    assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result offered during reset");

    // A stalled result transaction keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_data))
        else $error("result payload changed while stalled");

    // A negative next pointer always reports a halt.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.next_pointer[WORD_W-1] |-> result_data.halted)
        else $error("negative pointer without halt");

    // Configuration is refused whenever an instruction waits in execute.
    assert property (@(posedge clk) disable iff (!rst_n)
        !instr_ready |-> !cfg_ready)
        else $error("configuration accepted with an instruction in flight");

endmodule

bind register_machine_execute rme_checker u_rme_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .instr_ready  (instr.ready),
    .cfg_ready    (cfg.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

### bench/execution_monitor.sv
`timescale 1ns / 1ps

module execution_monitor
    import rme_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    rme_instr_if  instr,
    rme_cfg_if    cfg,
    rme_result_if result,
    output int    mismatches,
    output int    in_flight,
    output int    results_seen
);

    // Shadow copy of the machine state and its settings.
    logic [WORD_W-1:0]   regs [8];
    logic [WORD_W-1:0]   pointer;
    logic [BOUND_W-1:0]  bound_sel;
    logic [LENGTH_W-1:0] prog_length;

    // Outcomes of accepted instructions, oldest first.
    result_t predicted_outcomes [$];

    // Runs one instruction on the shadow state and returns the outcome it must produce.
    task automatic execute_instr(input instr_t ins, output result_t outcome);
        logic [WORD_W-1:0] imm_a;
        logic [WORD_W-1:0] imm_b;
        logic [WORD_W-1:0] reg_a;
        logic [WORD_W-1:0] reg_b;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] next_ptr;
        logic              bad_a;
        logic              bad_b;
        logic              bad;
        logic              bound_ok;

        // The bound register takes the pointer before anything is read.
        bound_ok = bound_sel < NUM_REGISTERS;
        if (bound_ok)
        begin
            regs[bound_sel] = pointer;
        end

        imm_a = WORD_W'(ins.operand_a);
        imm_b = WORD_W'(ins.operand_b);
        bad_a = ins.operand_a >= NUM_REGISTERS;
        bad_b = ins.operand_b >= NUM_REGISTERS;
        reg_a = bad_a ? '0 : regs[ins.operand_a[2:0]];
        reg_b = bad_b ? '0 : regs[ins.operand_b[2:0]];

        // Only operands that the opcode reads as register indexes can be flagged.
        case (ins.opcode)
            OP_ADDR: begin value = reg_a + reg_b;              bad = bad_a | bad_b; end
            OP_ADDI: begin value = reg_a + imm_b;              bad = bad_a;         end
            OP_MULR: begin value = reg_a * reg_b;              bad = bad_a | bad_b; end
            OP_MULI: begin value = reg_a * imm_b;              bad = bad_a;         end
            OP_BANR: begin value = reg_a & reg_b;              bad = bad_a | bad_b; end
            OP_BANI: begin value = reg_a & imm_b;              bad = bad_a;         end
            OP_BORR: begin value = reg_a | reg_b;              bad = bad_a | bad_b; end
            OP_BORI: begin value = reg_a | imm_b;              bad = bad_a;         end
            OP_SETR: begin value = reg_a;                      bad = bad_a;         end
            OP_SETI: begin value = imm_a;                      bad = 1'b0;          end
            OP_GTIR: begin value = WORD_W'($signed(imm_a) > $signed(reg_b)); bad = bad_b; end
            OP_GTRI: begin value = WORD_W'($signed(reg_a) > $signed(imm_b)); bad = bad_a; end
            OP_GTRR: begin
                value = WORD_W'($signed(reg_a) > $signed(reg_b));
                bad   = bad_a | bad_b;
            end
            OP_EQIR: begin value = WORD_W'(imm_a == reg_b);    bad = bad_b;         end
            OP_EQRI: begin value = WORD_W'(reg_a == imm_b);    bad = bad_a;         end
            default: begin value = WORD_W'(reg_a == reg_b);    bad = bad_a | bad_b; end
        endcase

        // A destination outside the file drops the write but still shows the value.
        if (ins.operand_c < NUM_REGISTERS)
        begin
            regs[ins.operand_c] = value;
        end
        else
        begin
            bad = 1'b1;
        end

        next_ptr = bound_ok ? regs[bound_sel] + 1 : pointer + 1;
        pointer  = next_ptr;

        outcome.next_pointer  = next_ptr;
        outcome.written_value = value;
        outcome.halted        = next_ptr[WORD_W-1] || (next_ptr >= WORD_W'(prog_length));
        outcome.bad_index     = bad;
    endtask

    // Compares one observed result with its prediction, field by field.
    task automatic compare_outcome(input result_t want, input result_t got);
        if (got.next_pointer !== want.next_pointer)
        begin
            $display("%0t: next_pointer expected %0d, got %0d",
                     $time, want.next_pointer, got.next_pointer);
            mismatches++;
        end
        if (got.written_value !== want.written_value)
        begin
            $display("%0t: written_value expected %0d, got %0d",
                     $time, want.written_value, got.written_value);
            mismatches++;
        end
        if (got.halted !== want.halted)
        begin
            $display("%0t: halted expected %0b, got %0b", $time, want.halted, got.halted);
            mismatches++;
        end
        if (got.bad_index !== want.bad_index)
        begin
            $display("%0t: bad_index expected %0b, got %0b",
                     $time, want.bad_index, got.bad_index);
            mismatches++;
        end
    endtask

    // Watch all three channels; every transaction is taken at the clock edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t outcome;

        if (!rst_n)
        begin
            regs         = '{default: '0};
            pointer      = '0;
            bound_sel    = '0;
            prog_length  = LENGTH_RESET;
            predicted_outcomes.delete();
            mismatches   = 0;
            in_flight    = 0;
            results_seen = 0;
        end
        else
        begin
            // Register writes.
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_BOUND_REGISTER)
                begin
                    bound_sel = cfg.wdata[BOUND_W-1:0];
                end
                else
                begin
                    prog_length = cfg.wdata[LENGTH_W-1:0];
                end
            end

            // Result transactions are matched against the oldest prediction.
            if (result.valid && result.ready)
            begin
                if (predicted_outcomes.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected, next_pointer %0d",
                             $time, result.data.next_pointer);
                    mismatches++;
                end
                else
                begin
                    compare_outcome(predicted_outcomes.pop_front(), result.data);
                    results_seen++;
                end
            end

            // Each instruction transaction yields exactly one outcome.
            if (instr.valid && instr.ready)
            begin
                execute_instr(instr.data, outcome);
                predicted_outcomes.push_back(outcome);
            end

            in_flight = predicted_outcomes.size();
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rme_pkg::*;

    logic clk   = 1'b0;
    logic rst_n;

    rme_instr_if  instr_ch ();
    rme_cfg_if    cfg_ch ();
    rme_result_if result_ch ();

    int mismatches;
    int in_flight;
    int results_seen;
    int items_sent   = 0;
    int settings_run = 0;

    // Idling controls shared by the two driving processes.
    bit source_quiet = 1'b0;
    bit sink_quiet   = 1'b0;
    bit hold_results = 1'b0;

    register_machine_execute DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    execution_monitor monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr        (instr_ch),
        .cfg          (cfg_ch),
        .result       (result_ch),
        .mismatches   (mismatches),
        .in_flight    (in_flight),
        .results_seen (results_seen)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic instr_t make_instr(opcode_t op, logic [OPERAND_W-1:0] a,
                                          logic [OPERAND_W-1:0] b, logic [DEST_W-1:0] c);
        instr_t ins;
        ins.opcode    = op;
        ins.operand_a = a;
        ins.operand_b = b;
        ins.operand_c = c;
        return ins;
    endfunction

    // Operands are mostly legal register indexes, sometimes just out of range,
    // sometimes a full-width immediate.
    function automatic logic [OPERAND_W-1:0] random_operand();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            return OPERAND_W'($urandom_range(0, NUM_REGISTERS - 1));
        end
        else if (pick == 7)
        begin
            return OPERAND_W'($urandom_range(NUM_REGISTERS, 64));
        end
        return OPERAND_W'($urandom);
    endfunction

    function automatic instr_t random_instr();
        logic [DEST_W-1:0] dest;
        if ($urandom_range(0, 9) == 0)
        begin
            dest = DEST_W'($urandom_range(NUM_REGISTERS, 7));
        end
        else
        begin
            dest = DEST_W'($urandom_range(0, NUM_REGISTERS - 1));
        end
        return make_instr(opcode_t'($urandom_range(0, 15)), random_operand(),
                          random_operand(), dest);
    endfunction

    // Offers one instruction after a random gap (none while source_quiet) and waits for its transaction.
    task automatic send_instr(input instr_t ins);
        int gap;
        gap = source_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.data  <= ins;
        do @(posedge clk); while (!instr_ch.ready);
        items_sent++;
    endtask

    // Stops offering instructions until every outstanding result is back.
    task automatic drain_results();
        instr_ch.valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic write_settings(input logic [BOUND_W-1:0] bound_sel,
                                  input logic [LENGTH_W-1:0] prog_length);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_BOUND_REGISTER;
        cfg_ch.wdata <= CFG_DATA_W'(bound_sel);
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.index <= CFG_PROGRAM_LENGTH;
        cfg_ch.wdata <= CFG_DATA_W'(prog_length);
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        settings_run++;
    endtask

    // Result side: random stalls after each transaction unless sink_quiet, plus one long hold-off on request.
    initial
    begin : result_sink
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        result_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            gap = 0;
            if (hold_results)
            begin
                gap          = 64;
                hold_results = 1'b0;
            end
            else if (result_ch.valid && result_ch.ready && !sink_quiet)
            begin
                gap = $urandom_range(0, 3);
            end
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        logic [BOUND_W-1:0]  bound_list  [8] = '{3'd1, 3'd5, 3'd6, 3'd2, 3'd7, 3'd3, 3'd4, 3'd0};
        logic [LENGTH_W-1:0] length_list [8] = '{9'd1, 9'd256, 9'd100, 9'd31,
                                                 9'd200, 9'd17, 9'd256, 9'd1};
        int wait_cycles;

        instr_ch.valid <= 1'b0;
        instr_ch.data  <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_BOUND_REGISTER;
        cfg_ch.wdata   <= '0;
        // Reset falls just after time zero so the asynchronous reset sees an edge.
        #1;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset settings: register 0 follows the pointer.
        // Build a register holding all ones from 2^32-1 times 2^32+1.
        send_instr(make_instr(OP_SETI, 31'h7FFF_FFFF, 31'd0, 3'd1));
        send_instr(make_instr(OP_MULI, 31'd1, 31'd2, 3'd2));
        send_instr(make_instr(OP_ADDI, 31'd2, 31'd1, 3'd2));
        send_instr(make_instr(OP_ADDI, 31'd2, 31'd2, 3'd3));
        send_instr(make_instr(OP_MULR, 31'd2, 31'd3, 3'd4));
        // Signed comparisons against a negative register.
        send_instr(make_instr(OP_GTIR, 31'h7FFF_FFFF, 31'd4, 3'd5));
        send_instr(make_instr(OP_GTRI, 31'd4, 31'h7FFF_FFFF, 3'd5));
        send_instr(make_instr(OP_GTRR, 31'd1, 31'd4, 3'd5));
        send_instr(make_instr(OP_EQRR, 31'd4, 31'd4, 3'd5));
        send_instr(make_instr(OP_EQIR, 31'd5, 31'd0, 3'd5));
        send_instr(make_instr(OP_EQRI, 31'd1, 31'h7FFF_FFFF, 3'd5));
        // Bitwise and wrapping arithmetic.
        send_instr(make_instr(OP_ADDR, 31'd1, 31'd4, 3'd5));
        send_instr(make_instr(OP_BANR, 31'd4, 31'd2, 3'd5));
        send_instr(make_instr(OP_BANI, 31'd4, 31'h5555_5555, 3'd5));
        send_instr(make_instr(OP_BORR, 31'd1, 31'd3, 3'd5));
        send_instr(make_instr(OP_BORI, 31'd5, 31'h2AAA_AAAA, 3'd5));
        // An ignored operand B must not raise the index flag.
        send_instr(make_instr(OP_SETR, 31'd4, 31'h7FFF_FFFF, 3'd5));
        // Illegal source indexes read zero; an illegal destination drops the write.
        send_instr(make_instr(OP_ADDR, 31'd6, 31'd7, 3'd5));
        send_instr(make_instr(OP_MULI, 31'h7FFF_FFFF, 31'd3, 3'd5));
        send_instr(make_instr(OP_SETI, 31'd9, 31'd0, 3'd7));
        // Pointer jumps: wrap to zero, past the end, negative, and the halt boundary.
        send_instr(make_instr(OP_SETR, 31'd4, 31'd0, 3'd0));
        send_instr(make_instr(OP_ADDI, 31'd0, 31'd40, 3'd0));
        send_instr(make_instr(OP_ADDR, 31'd4, 31'd4, 3'd0));
        send_instr(make_instr(OP_SETI, 31'd30, 31'd0, 3'd0));
        send_instr(make_instr(OP_SETI, 31'd29, 31'd0, 3'd0));

        // Random part over a series of settings, ending with fully random ones.
        for (int stage = 0; stage < 10; stage++)
        begin
            if (stage < 8)
            begin
                write_settings(bound_list[stage], length_list[stage]);
            end
            else
            begin
                write_settings(BOUND_W'($urandom_range(0, 7)),
                               LENGTH_W'($urandom_range(1, 256)));
            end
            source_quiet = (stage % 3 == 1);
            sink_quiet   = (stage % 3 == 1);
            if (stage == 2)
            begin
                hold_results = 1'b1;
            end
            for (int n = 0; n < 75; n++)
            begin
                if (stage == 3 && n == 40)
                begin
                    drain_results();
                end
                send_instr(random_instr());
            end
        end

        // Let the last results come back, within a bound.
        instr_ch.valid <= 1'b0;
        @(posedge clk);
        wait_cycles = 0;
        while (in_flight != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        if (in_flight != 0)
        begin
            $display("%0t: %0d predicted results never arrived", $time, in_flight);
        end

        $display("Executed %0d instructions under %0d register settings; %0d results compared.",
                 items_sent, settings_run + 1, results_seen);
        if (mismatches == 0 && in_flight == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/rme_pkg.sv
hw/rtl/rme_instr_if.sv
hw/rtl/rme_result_if.sv
hw/rtl/rme_cfg_if.sv
hw/rtl/register_machine_execute.sv
hw/rtl/rme_checker.sv
bench/execution_monitor.sv
bench/testbench.sv
